@@ rtl/core/free_page_stack_allocator_core_defines.svh @@
// ----------------------------------------------------------------------------
// free page stack allocator: assertion macros
// shared property wrappers, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef FREE_PAGE_STACK_ALLOCATOR_CORE_DEFINES_SVH
`define FREE_PAGE_STACK_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define FPSA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FPSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/fpsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsa_pkg
// types and fixed constants of the free page stack allocator
// ----------------------------------------------------------------------------
package fpsa_pkg;

	// request kinds
	typedef enum logic [1:0] {
		MODE_INIT  = 2'd0,
		MODE_FREE  = 2'd1,
		MODE_ALLOC = 2'd2,
		MODE_QUERY = 2'd3
	} mode_t;

	// result status
	typedef enum logic [1:0] {
		ERR_OK         = 2'd0,
		ERR_BAD_ADDR   = 2'd1,
		ERR_STACK_FULL = 2'd2
	} err_t;

	localparam int ADDR_FIELD_W = 32;
	localparam int FREE_BYTES_W = 28;
	localparam int CFG_DATA_W   = 32;

	typedef logic [ADDR_FIELD_W-1:0] addr_field_t;
	typedef logic [FREE_BYTES_W-1:0] free_bytes_t;
	typedef logic [CFG_DATA_W-1:0]   cfg_data_t;
	typedef logic                    cfg_index_t;

	// configuration register indexes
	localparam cfg_index_t REG_HEAP_START = 1'b0;
	localparam cfg_index_t REG_HEAP_STOP  = 1'b1;

	localparam cfg_data_t   HEAP_START_RESET = 32'h8000_0000;
	localparam cfg_data_t   HEAP_STOP_RESET  = 32'h8800_0000;
	localparam free_bytes_t FREE_BYTES_MAX   = 28'hFFF_FFFF;

endpackage

@@ rtl/core/fpsa_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpsa request and response channels
// valid/ready channels carrying one request or one result per beat
// ----------------------------------------------------------------------------
interface fpsa_req_if;
	import fpsa_pkg::*;

	logic        valid;
	logic        ready;
	mode_t       mode;
	addr_field_t page_address;

	modport source (output valid, output mode, output page_address, input ready);
	modport sink   (input valid, input mode, input page_address, output ready);
endinterface

interface fpsa_rsp_if;
	import fpsa_pkg::*;

	logic        valid;
	logic        ready;
	addr_field_t granted_address;
	logic        granted;
	err_t        error_code;
	free_bytes_t free_bytes;

	modport source (output valid, output granted_address, output granted,
		output error_code, output free_bytes, input ready);
	modport sink   (input valid, input granted_address, input granted,
		input error_code, input free_bytes, output ready);
endinterface

@@ rtl/core/free_page_stack_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free page stack allocator core
// lifo allocator of physical pages: init, free, alloc and query requests
// ----------------------------------------------------------------------------
// Each request beat is accepted in ST_IDLE and passes through ST_EXEC, where
// its result enters the output register once that register is free. A new
// request is not taken until the previous one has left ST_EXEC, and a result
// that is still waiting in the output register holds the next request back.
// ST_EXEC is there because a pop must wait for the registered read of the
// freed-page stack memory. Init empties the stack and sets a watermark just
// above the highest whole page below the stop address. Free checks alignment
// and the range [start, stop) against the current registers and flags a
// misaligned or out-of-range address (error 1) or a full stack (error 2).
// Alloc pops the stack, or if it is empty lowers the watermark, and grants
// nothing when no page is left above the base. The stack memory is not
// cleared after reset: only pushed entries are ever read, so requests are
// taken as soon as reset is released. Configuration must be written
// while no request is in flight.
// ----------------------------------------------------------------------------
`include "free_page_stack_allocator_core_defines.svh"

module free_page_stack_allocator_core #(
	parameter int PAGE_SHIFT  = 12,
	parameter int STACK_DEPTH = 32768,
	parameter int ADDR_WIDTH  = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	fpsa_req_if.sink             req,
	fpsa_rsp_if.source           rsp,
	input  logic                 cfg_we,
	input  fpsa_pkg::cfg_index_t cfg_index,
	input  fpsa_pkg::cfg_data_t  cfg_data
);
	import fpsa_pkg::*;

	// address bits in use: the fields are 32 bits, so wider addresses add nothing
	localparam int UW = (ADDR_WIDTH < ADDR_FIELD_W) ? ADDR_WIDTH : ADDR_FIELD_W;
	// page number width, kept at least one bit for the degenerate corner
	localparam int PW = (UW > PAGE_SHIFT) ? (UW - PAGE_SHIFT) : 1;
	// base page may sit one above the top page number
	localparam int PB = PW + 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SW = ((PW > CW) ? PW : CW) + 1;
	localparam int QW = (SW > FREE_BYTES_W) ? SW : FREE_BYTES_W;
	localparam int GW = PW + PAGE_SHIFT;
	localparam free_bytes_t FB_PAGE_LIMIT = FREE_BYTES_MAX >> PAGE_SHIFT;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// configuration registers
	logic [UW-1:0] start_q;
	logic [UW-1:0] stop_q;

	// allocator state
	logic [CW-1:0] count_q;
	logic [PW-1:0] wm_q;
	logic [PB-1:0] base_q;

	// freed-page stack
	logic [PW-1:0] stack_mem [STACK_DEPTH];
	logic [PW-1:0] rd_q;

	// request in flight and output register
	state_t        state_q;
	logic          pop_q;
	addr_field_t   res_ga_q;
	logic          res_granted_q;
	err_t          res_err_q;
	free_bytes_t   res_fb_q;
	logic          out_valid_q;
	addr_field_t   out_ga_q;
	logic          out_granted_q;
	err_t          out_err_q;
	free_bytes_t   out_fb_q;

	// request decode
	logic          req_acc;
	logic [UW-1:0] addr_m;
	logic [PW-1:0] req_page;
	logic          addr_bad;
	logic          stack_full;
	logic          stack_nonempty;
	logic          region_avail;
	logic [PW-1:0] region_pages;
	logic [SW-1:0] pages;
	logic [QW-1:0] pages_ext;
	logic [QW-1:0] pages_bytes;
	free_bytes_t   query_fb;
	logic [PB-1:0] init_base;
	logic [PW-1:0] init_wm;
	logic [PW-1:0] wm_dec;
	logic [GW-1:0] wm_ga_full;
	logic [GW-1:0] pop_ga_full;
	logic          push_en;
	logic          pop_en;
	logic [IW-1:0] push_idx;
	logic [IW-1:0] pop_idx;
	logic [CW-1:0] count_dec;
	logic          out_free;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	always_comb begin
		addr_m         = req.page_address[UW-1:0];
		req_page       = PW'(addr_m >> PAGE_SHIFT);
		// misaligned, below start or at or above stop
		addr_bad       = (|addr_m[PAGE_SHIFT-1:0]) || (addr_m < start_q) || (addr_m >= stop_q);
		stack_full     = (count_q >= CW'(STACK_DEPTH));
		stack_nonempty = (count_q != '0);
		region_avail   = ({1'b0, wm_q} > base_q);
		region_pages   = region_avail ? PW'({1'b0, wm_q} - base_q) : '0;
		pages          = SW'(count_q) + SW'(region_pages);
		pages_ext      = QW'(pages);
		pages_bytes    = pages_ext << PAGE_SHIFT;
		// saturate beyond the field
		query_fb       = (pages_ext > QW'(FB_PAGE_LIMIT)) ? FREE_BYTES_MAX
			: pages_bytes[FREE_BYTES_W-1:0];
		// first whole page at or above start; watermark just above the last whole page below stop
		init_base      = PB'(start_q >> PAGE_SHIFT) + PB'(|start_q[PAGE_SHIFT-1:0]);
		init_wm        = PW'(stop_q >> PAGE_SHIFT);
		wm_dec         = wm_q - 1'b1;
		wm_ga_full     = {wm_dec, {PAGE_SHIFT{1'b0}}};
		pop_ga_full    = {rd_q, {PAGE_SHIFT{1'b0}}};
		count_dec      = count_q - 1'b1;
		push_idx       = count_q[IW-1:0];
		pop_idx        = count_dec[IW-1:0];
		push_en        = req_acc && (req.mode == MODE_FREE) && !addr_bad && !stack_full;
		pop_en         = req_acc && (req.mode == MODE_ALLOC) && stack_nonempty;
	end

	// stack memory: write on push, registered read on pop; a push and a later
	// pop of the same entry never fall in the same cycle, as each request passes ST_EXEC
	always_ff @(posedge clk) begin
		if (push_en) begin
			stack_mem[push_idx] <= req_page;
		end
		if (pop_en) begin
			rd_q <= stack_mem[pop_idx];
		end
	end

	// configuration registers; the user must write them only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= HEAP_START_RESET[UW-1:0];
			stop_q  <= HEAP_STOP_RESET[UW-1:0];
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEAP_START: start_q <= cfg_data[UW-1:0];
				REG_HEAP_STOP:  stop_q  <= cfg_data[UW-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, allocator state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			wm_q        <= '0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a beat leaving while a new result is loaded is handled in ST_EXEC
			if (out_valid_q && rsp.ready && (state_q != ST_EXEC)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						state_q       <= ST_EXEC;
						pop_q         <= 1'b0;
						res_ga_q      <= '0;
						res_granted_q <= 1'b0;
						res_err_q     <= ERR_OK;
						res_fb_q      <= '0;
						case (req.mode)
							MODE_INIT: begin
								count_q <= '0;
								base_q  <= init_base;
								wm_q    <= init_wm;
							end
							MODE_FREE: begin
								if (addr_bad) begin
									res_err_q <= ERR_BAD_ADDR;
								end else if (stack_full) begin
									res_err_q <= ERR_STACK_FULL;
								end else begin
									count_q <= count_q + 1'b1;
								end
							end
							MODE_ALLOC: begin
								if (stack_nonempty) begin
									// address comes from the stack read next cycle
									count_q       <= count_dec;
									pop_q         <= 1'b1;
									res_granted_q <= 1'b1;
								end else if (region_avail) begin
									wm_q          <= wm_dec;
									res_ga_q      <= ADDR_FIELD_W'(wm_ga_full[UW-1:0]);
									res_granted_q <= 1'b1;
								end
							end
							MODE_QUERY: begin
								res_fb_q <= query_fb;
							end
							default: ;
						endcase
					end
				end
				ST_EXEC: begin
					// hold here while the previous result is still waiting
					if (out_free) begin
						state_q       <= ST_IDLE;
						out_valid_q   <= 1'b1;
						out_ga_q      <= pop_q ? ADDR_FIELD_W'(pop_ga_full[UW-1:0]) : res_ga_q;
						out_granted_q <= res_granted_q;
						out_err_q     <= res_err_q;
						out_fb_q      <= res_fb_q;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.granted_address = out_ga_q;
	assign rsp.granted         = out_granted_q;
	assign rsp.error_code      = out_err_q;
	assign rsp.free_bytes      = out_fb_q;

	`FPSA_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(STACK_DEPTH), "stack count above depth")
	`FPSA_ASSERT_NEXT(a_push_count, push_en, count_q == $past(count_q) + 1'b1, "push lost count")
	`FPSA_ASSERT_NEXT(a_wm_monotone, req_acc && (req.mode != MODE_INIT),
		wm_q <= $past(wm_q), "watermark rose outside init")
	`FPSA_ASSERT_SAME(a_grant_clean, out_valid_q && out_granted_q,
		(out_err_q == ERR_OK) && (out_fb_q == '0), "grant with error or byte count")

endmodule
